// ----- rtl/core/sdspi_pkg.sv -----
// Shared types and constants for the SD card SPI host engine.
package sdspi_pkg;

	localparam int unsigned SectorBytes = 512;
	localparam int unsigned DummyBytes  = 10;
	localparam int unsigned CntW        = $clog2(SectorBytes + 1);

	typedef enum logic [1:0] {
		FUNC_INIT  = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_WRITE = 2'd2,
		FUNC_XCHG  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		CFG_POLL  = 3'd0,
		CFG_RST   = 3'd1,
		CFG_IFC   = 3'd2,
		CFG_OPC   = 3'd3,
		CFG_TOKEN = 3'd4,
		CFG_BUSY  = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_REJECT   = 2'd1,
		ST_TIMEOUT  = 2'd2,
		ST_WR_ERROR = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		PH_IDLE, PH_DUMMY, PH_CMD_SEND, PH_CMD_POLL, PH_CMD_OCR, PH_CMD_TAIL,
		PH_GAP, PH_RD_TOKEN, PH_RD_DATA, PH_RD_TAIL, PH_WR_TOKEN, PH_WR_DATA,
		PH_WR_CRC, PH_WR_RESP, PH_WR_BUSY1, PH_WR_GAP, PH_WR_BUSY2
	} phase_t;

	// One classified item as it travels from the front to the sequencer.
	typedef struct packed {
		func_t       func;
		logic [31:0] block_number;
		logic [7:0]  miso_byte;
		logic [7:0]  write_byte;
	} item_t;

	// One result item.
	typedef struct packed {
		logic [7:0] mosi_byte;
		logic       exchange_request;
		logic       card_select;
		logic       need_write_data;
		logic [7:0] read_byte;
		logic       read_valid;
		logic       op_done;
		status_t    op_status;
		logic       card_is_sdhc;
	} result_t;

	// Configuration limits.
	typedef struct packed {
		logic [7:0]  poll;
		logic [7:0]  rst;
		logic [7:0]  ifc;
		logic [11:0] opc;
		logic [15:0] token;
		logic [15:0] busy;
	} limits_t;

endpackage

// ----- rtl/core/sdspi_fifo.sv -----
// Two-entry queue between the front and the sequencer.
module sdspi_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  sdspi_pkg::item_t   wr_data,
	output logic               full,
	input  logic               rd_en,
	output sdspi_pkg::item_t   rd_data,
	output logic               empty
);

	sdspi_pkg::item_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign rd_data = mem_q[rp_q];

	// Storage is written at the write pointer.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wp_q <= ~wp_q;
			if (rd_en) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_en};
		end
	end

endmodule

// ----- rtl/core/sdspi_front.sv -----
// Input front: takes item beats and the configuration port.
module sdspi_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         func,
	input  logic [31:0]        block_number,
	input  logic [7:0]         miso_byte,
	input  logic [7:0]         write_byte,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output sdspi_pkg::limits_t limits,
	output logic               q_wr,
	output sdspi_pkg::item_t   q_data,
	input  logic               q_full
);

	sdspi_pkg::limits_t lim_q;

	assign full   = q_full;
	assign q_wr   = push && !q_full;
	assign q_data = '{func: sdspi_pkg::func_t'(func), block_number: block_number,
		miso_byte: miso_byte, write_byte: write_byte};
	assign limits = lim_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= '{poll: 8'd254, rst: 8'd32, ifc: 8'd254, opc: 12'd4094,
				token: 16'd65534, busy: 16'd65534};
		end else if (cfg_we) begin
			unique case (cfg_index)
				sdspi_pkg::CFG_POLL:  lim_q.poll  <= cfg_data[7:0];
				sdspi_pkg::CFG_RST:   lim_q.rst   <= cfg_data[7:0];
				sdspi_pkg::CFG_IFC:   lim_q.ifc   <= cfg_data[7:0];
				sdspi_pkg::CFG_OPC:   lim_q.opc   <= cfg_data[11:0];
				sdspi_pkg::CFG_TOKEN: lim_q.token <= cfg_data;
				sdspi_pkg::CFG_BUSY:  lim_q.busy  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/core/sdspi_seq.sv -----
// Back-end sequencer: one queued item in, one result beat out.
module sdspi_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  sdspi_pkg::limits_t limits,
	input  logic               q_empty,
	input  sdspi_pkg::item_t   q_data,
	output logic               q_rd,
	output logic               empty,
	input  logic               pop,
	output sdspi_pkg::result_t result
);

	localparam logic [sdspi_pkg::CntW-1:0] SecLast = sdspi_pkg::CntW'(sdspi_pkg::SectorBytes);
	localparam logic [sdspi_pkg::CntW-1:0] DumLast = sdspi_pkg::CntW'(sdspi_pkg::DummyBytes);

	sdspi_pkg::phase_t  phase_q, phase_d;
	logic [1:0]  kind_q, kind_d;
	logic [11:0] retry_q, retry_d;
	logic [15:0] wait_q, wait_d;
	logic [sdspi_pkg::CntW-1:0] bcnt_q, bcnt_d, bcnt_inc;
	logic [5:0]  cidx_q, cidx_d;
	logic [31:0] carg_q, carg_d;
	logic        sdhc_q, sdhc_d, v2_q, v2_d;
	logic [7:0]  last_q, last_d;
	sdspi_pkg::result_t res, res_q;
	logic        full_q;
	logic        step;
	logic [7:0]  r;

	// Result holding register; a beat is taken when the slot is free or being popped.
	assign empty  = !full_q;
	assign result = res_q;
	assign step   = !q_empty && (!full_q || pop);
	assign q_rd   = step;
	assign r      = q_data.miso_byte;
	assign bcnt_inc = bcnt_q + 1'b1;

	function automatic logic [7:0] frame(input logic [5:0] idx, input logic [31:0] arg,
			input logic [sdspi_pkg::CntW-1:0] k);
		logic [7:0] b;
		case (k)
			0: b = {2'b01, idx};
			1: b = arg[31:24];
			2: b = arg[23:16];
			3: b = arg[15:8];
			4: b = arg[7:0];
			default: b = (idx == 6'd8) ? 8'h87 : 8'h95;
		endcase
		return b;
	endfunction

	// Next state and result for one item.
	always_comb begin
		logic [31:0] a;
		logic        go_cmd;
		logic [5:0]  ni;
		logic [31:0] na;
		phase_d = phase_q; kind_d = kind_q; retry_d = retry_q; wait_d = wait_q;
		bcnt_d = bcnt_q; cidx_d = cidx_q; carg_d = carg_q; sdhc_d = sdhc_q;
		v2_d = v2_q; last_d = last_q;
		go_cmd = 1'b0; ni = '0; na = '0;
		res = '{mosi_byte: 8'hFF, exchange_request: 1'b0, card_select: 1'b0,
			need_write_data: 1'b0, read_byte: 8'h00, read_valid: 1'b0,
			op_done: 1'b0, op_status: sdspi_pkg::ST_OK, card_is_sdhc: 1'b0};
		a = sdhc_q ? q_data.block_number : {q_data.block_number[22:0], 9'd0};
		if (q_data.func != sdspi_pkg::FUNC_XCHG) begin
			kind_d = q_data.func; retry_d = '0; wait_d = '0;
			if (q_data.func == sdspi_pkg::FUNC_INIT) begin
				v2_d = 1'b1; phase_d = sdspi_pkg::PH_DUMMY; bcnt_d = '0;
				res.exchange_request = 1'b1;
			end else begin
				go_cmd = 1'b1;
				ni = (q_data.func == sdspi_pkg::FUNC_READ) ? 6'd17 : 6'd24;
				na = a;
			end
		end else begin
			unique case (phase_q)
				sdspi_pkg::PH_DUMMY: begin
					bcnt_d = bcnt_inc;
					if (bcnt_inc < DumLast) res.exchange_request = 1'b1;
					else begin retry_d = '0; go_cmd = 1'b1; ni = 6'd0; na = '0; end
				end
				sdspi_pkg::PH_CMD_SEND: begin
					bcnt_d = bcnt_inc; res.exchange_request = 1'b1; res.card_select = 1'b1;
					if (bcnt_inc < 6) res.mosi_byte = frame(cidx_q, carg_q, bcnt_inc);
					else begin phase_d = sdspi_pkg::PH_CMD_POLL; wait_d = '0; end
				end
				sdspi_pkg::PH_CMD_POLL: begin
					res.exchange_request = 1'b1; res.card_select = 1'b1;
					if (r == 8'hFF && !(wait_q > {8'd0, limits.poll} || wait_q == 16'hFFFF))
						wait_d = wait_q + 1'b1;
					else begin
						last_d = r; bcnt_d = '0;
						phase_d = (r == 8'h00 && cidx_q == 6'd58) ? sdspi_pkg::PH_CMD_OCR
							: sdspi_pkg::PH_CMD_TAIL;
					end
				end
				sdspi_pkg::PH_CMD_OCR: begin
					if (bcnt_q == '0) sdhc_d = r[6];
					bcnt_d = bcnt_inc;
					if (bcnt_inc >= 4) phase_d = sdspi_pkg::PH_CMD_TAIL;
					res.exchange_request = 1'b1; res.card_select = 1'b1;
				end
				sdspi_pkg::PH_CMD_TAIL: begin
					if (kind_q != sdspi_pkg::FUNC_INIT) begin
						if (last_q != 8'h00) begin
							phase_d = sdspi_pkg::PH_IDLE; res.op_done = 1'b1;
							res.op_status = sdspi_pkg::ST_REJECT;
						end else if (kind_q == sdspi_pkg::FUNC_READ) begin
							phase_d = sdspi_pkg::PH_RD_TOKEN; wait_d = '0;
							res.exchange_request = 1'b1; res.card_select = 1'b1;
						end else begin
							phase_d = sdspi_pkg::PH_WR_TOKEN; bcnt_d = '0;
							res.exchange_request = 1'b1; res.card_select = 1'b1;
							res.mosi_byte = 8'hFE; res.need_write_data = 1'b1;
						end
					end else begin
						case (cidx_q)
							6'd0: begin
								if (last_q == 8'h01) begin
									phase_d = sdspi_pkg::PH_GAP; bcnt_d = '0;
									res.exchange_request = 1'b1;
								end else if (retry_q > {4'd0, limits.rst}) begin
									phase_d = sdspi_pkg::PH_IDLE; res.op_done = 1'b1;
									res.op_status = sdspi_pkg::ST_REJECT;
								end else begin
									retry_d = retry_q + 1'b1; go_cmd = 1'b1;
									ni = 6'd0; na = '0;
								end
							end
							6'd8: begin
								go_cmd = 1'b1;
								if (last_q == 8'h01) begin
									retry_d = '0; ni = 6'd55; na = '0;
								end else if (retry_q > {4'd0, limits.ifc}) begin
									v2_d = 1'b0; retry_d = '0; ni = 6'd55; na = '0;
								end else begin
									retry_d = retry_q + 1'b1; ni = 6'd8; na = 32'h000001AA;
								end
							end
							6'd55: begin
								go_cmd = 1'b1; ni = 6'd1; na = 32'h40000000;
							end
							6'd1: begin
								if (retry_q >= limits.opc) begin
									phase_d = sdspi_pkg::PH_IDLE; res.op_done = 1'b1;
									res.op_status = sdspi_pkg::ST_TIMEOUT;
								end else if (last_q != 8'h00) begin
									retry_d = retry_q + 1'b1; go_cmd = 1'b1;
									ni = 6'd55; na = '0;
								end else begin
									retry_d = '0; sdhc_d = 1'b0;
									if (v2_q) begin go_cmd = 1'b1; ni = 6'd58; na = '0; end
									else begin phase_d = sdspi_pkg::PH_IDLE; res.op_done = 1'b1; end
								end
							end
							default: begin
								if (last_q == 8'h00 || retry_q > 12'hFE) begin
									phase_d = sdspi_pkg::PH_IDLE; res.op_done = 1'b1;
								end else begin
									retry_d = retry_q + 1'b1; go_cmd = 1'b1;
									ni = 6'd58; na = '0;
								end
							end
						endcase
					end
				end
				sdspi_pkg::PH_GAP: begin
					bcnt_d = bcnt_inc;
					if (bcnt_inc < 2) res.exchange_request = 1'b1;
					else begin retry_d = '0; go_cmd = 1'b1; ni = 6'd8; na = 32'h000001AA; end
				end
				sdspi_pkg::PH_RD_TOKEN: begin
					if (r == 8'hFE) begin
						phase_d = sdspi_pkg::PH_RD_DATA; bcnt_d = '0;
						res.exchange_request = 1'b1; res.card_select = 1'b1;
					end else if (wait_q > limits.token || wait_q == 16'hFFFF) begin
						phase_d = sdspi_pkg::PH_IDLE; res.op_done = 1'b1;
						res.op_status = sdspi_pkg::ST_TIMEOUT;
					end else begin
						wait_d = wait_q + 1'b1;
						res.exchange_request = 1'b1; res.card_select = 1'b1;
					end
				end
				sdspi_pkg::PH_RD_DATA: begin
					res.read_byte = r; res.read_valid = 1'b1; bcnt_d = bcnt_inc;
					if (bcnt_inc >= SecLast) begin phase_d = sdspi_pkg::PH_RD_TAIL; bcnt_d = '0; end
					res.exchange_request = 1'b1; res.card_select = 1'b1;
				end
				sdspi_pkg::PH_RD_TAIL: begin
					bcnt_d = bcnt_inc;
					if (bcnt_inc < 3) begin
						res.exchange_request = 1'b1; res.card_select = 1'b1;
					end else begin phase_d = sdspi_pkg::PH_IDLE; res.op_done = 1'b1; end
				end
				sdspi_pkg::PH_WR_TOKEN: begin
					phase_d = sdspi_pkg::PH_WR_DATA; bcnt_d = '0;
					res.exchange_request = 1'b1; res.card_select = 1'b1;
					res.mosi_byte = q_data.write_byte; res.need_write_data = 1'b1;
				end
				sdspi_pkg::PH_WR_DATA: begin
					bcnt_d = bcnt_inc;
					res.exchange_request = 1'b1; res.card_select = 1'b1;
					if (bcnt_inc < SecLast) begin
						res.mosi_byte = q_data.write_byte;
						res.need_write_data = (bcnt_inc + 1'b1) < SecLast;
					end else begin phase_d = sdspi_pkg::PH_WR_CRC; bcnt_d = '0; end
				end
				sdspi_pkg::PH_WR_CRC: begin
					bcnt_d = bcnt_inc;
					if (bcnt_inc >= 2) phase_d = sdspi_pkg::PH_WR_RESP;
					res.exchange_request = 1'b1; res.card_select = 1'b1;
				end
				sdspi_pkg::PH_WR_RESP: begin
					if (r[4:0] != 5'h05) begin
						phase_d = sdspi_pkg::PH_IDLE; res.op_done = 1'b1;
						res.op_status = sdspi_pkg::ST_WR_ERROR;
					end else begin
						phase_d = sdspi_pkg::PH_WR_BUSY1; wait_d = '0;
						res.exchange_request = 1'b1; res.card_select = 1'b1;
					end
				end
				sdspi_pkg::PH_WR_BUSY1, sdspi_pkg::PH_WR_BUSY2: begin
					if (r != 8'h00) begin
						if (phase_q == sdspi_pkg::PH_WR_BUSY1) begin
							phase_d = sdspi_pkg::PH_WR_GAP; res.exchange_request = 1'b1;
						end else begin phase_d = sdspi_pkg::PH_IDLE; res.op_done = 1'b1; end
					end else if (wait_q > limits.busy || wait_q == 16'hFFFF) begin
						phase_d = sdspi_pkg::PH_IDLE; res.op_done = 1'b1;
						res.op_status = sdspi_pkg::ST_WR_ERROR;
					end else begin
						wait_d = wait_q + 1'b1;
						res.exchange_request = 1'b1; res.card_select = 1'b1;
					end
				end
				sdspi_pkg::PH_WR_GAP: begin
					phase_d = sdspi_pkg::PH_WR_BUSY2;
					res.exchange_request = 1'b1; res.card_select = 1'b1;
				end
				default: ;
			endcase
		end
		// Start of a command frame.
		if (go_cmd) begin
			cidx_d = ni; carg_d = na; bcnt_d = '0; phase_d = sdspi_pkg::PH_CMD_SEND;
			res.exchange_request = 1'b1; res.card_select = 1'b1;
			res.mosi_byte = {2'b01, ni};
		end
		res.card_is_sdhc = sdhc_d;
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sdspi_pkg::PH_IDLE; kind_q <= '0; retry_q <= '0; wait_q <= '0;
			bcnt_q <= '0; cidx_q <= '0; carg_q <= '0; sdhc_q <= 1'b0; v2_q <= 1'b1;
			last_q <= 8'hFF; full_q <= 1'b0;
		end else begin
			if (step) begin
				phase_q <= phase_d; kind_q <= kind_d; retry_q <= retry_d; wait_q <= wait_d;
				bcnt_q <= bcnt_d; cidx_q <= cidx_d; carg_q <= carg_d; sdhc_q <= sdhc_d;
				v2_q <= v2_d; last_q <= last_d;
				full_q <= 1'b1;
			end else if (pop) begin
				full_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (step) res_q <= res;
	end

endmodule

// ----- rtl/core/sd_card_spi_host_engine.sv -----
// Top level of the SD card SPI-mode host engine.
// Usage: each input beat (push/full) is either a start request (init, read
// sector, write sector) or the report of one finished SPI byte exchange with
// the byte the card returned. Each input beat yields exactly one result beat
// (empty/pop) naming the next byte to shift out, chip select, whether a sector
// byte must come with the next report, a received sector byte, and completion
// status. Limits are set through the cfg_we/cfg_index/cfg_data write port
// while the engine is idle.
// Each beat passes through the queue and then the result register. Throughput:
// one item per cycle while results are popped; the sequencer updates all its
// state together for each item, and a two-entry queue separates the input
// front from it. Reset empties the queue and the result register and returns
// all limits to their defaults. When the result receiver stalls, the result
// register holds, the queue fills and full rises after two more beats.
module sd_card_spi_host_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  func,
	input  logic [31:0] block_number,
	input  logic [7:0]  miso_byte,
	input  logic [7:0]  write_byte,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  mosi_byte,
	output logic        exchange_request,
	output logic        card_select,
	output logic        need_write_data,
	output logic [7:0]  read_byte,
	output logic        read_valid,
	output logic        op_done,
	output logic [1:0]  op_status,
	output logic        card_is_sdhc,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	sdspi_pkg::limits_t limits;
	sdspi_pkg::item_t   wdata, rdata;
	sdspi_pkg::result_t res;
	logic q_wr, q_full, q_rd, q_empty;

	sdspi_front u_front (
		.clk, .arst_n, .push, .full, .func, .block_number, .miso_byte, .write_byte,
		.cfg_we, .cfg_index, .cfg_data, .limits, .q_wr, .q_data(wdata), .q_full
	);

	sdspi_fifo u_fifo (
		.clk, .arst_n, .wr_en(q_wr), .wr_data(wdata), .full(q_full),
		.rd_en(q_rd), .rd_data(rdata), .empty(q_empty)
	);

	sdspi_seq u_seq (
		.clk, .arst_n, .limits, .q_empty, .q_data(rdata), .q_rd,
		.empty, .pop, .result(res)
	);

	// Result fields onto their ports.
	assign mosi_byte        = res.mosi_byte;
	assign exchange_request = res.exchange_request;
	assign card_select      = res.card_select;
	assign need_write_data  = res.need_write_data;
	assign read_byte        = res.read_byte;
	assign read_valid       = res.read_valid;
	assign op_done          = res.op_done;
	assign op_status        = res.op_status;
	assign card_is_sdhc     = res.card_is_sdhc;

endmodule

// ----- dv/sd_card_spi_host_engine_test.sv -----
// Self-checking testbench for the SD card SPI host engine.
module sd_card_spi_host_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CycleLimit = 400000;
	localparam int unsigned HoldCycles = 60;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [1:0]  func;
	logic [31:0] block_number;
	logic [7:0]  miso_byte;
	logic [7:0]  write_byte;
	logic        empty;
	logic        pop;
	logic [7:0]  mosi_byte;
	logic        exchange_request;
	logic        card_select;
	logic        need_write_data;
	logic [7:0]  read_byte;
	logic        read_valid;
	logic        op_done;
	logic [1:0]  op_status;
	logic        card_is_sdhc;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	sd_card_spi_host_engine dut (.*);

	// Beats waiting to be offered and results the engine still owes.
	sdspi_pkg::item_t   pending_beats[$];
	sdspi_pkg::result_t awaited_results[$];
	int unsigned errors;
	int unsigned cycles;
	bit quiet;
	bit hold_request;
	int unsigned hold_cnt;
	int unsigned send_gap;
	int unsigned pop_gap;
	bit in_taken;

	// Local copy of the sequencer state and the limits.
	sdspi_pkg::phase_t  ph;
	logic [1:0]         kind;
	logic [11:0]        rcnt;
	logic [15:0]        wcnt;
	logic [9:0]         bcnt;
	logic [5:0]         cidx;
	logic [31:0]        carg;
	logic               sdhc;
	logic               v2;
	logic [7:0]         lastr;
	sdspi_pkg::limits_t lim;
	sdspi_pkg::result_t res;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void xfer(input logic [7:0] m, input logic cs);
		res.mosi_byte = m;
		res.exchange_request = 1'b1;
		res.card_select = cs;
	endfunction

	function automatic void finish_op(input sdspi_pkg::status_t st);
		ph = sdspi_pkg::PH_IDLE;
		res.op_done = 1'b1;
		res.op_status = st;
	endfunction

	function automatic bit retry_over(input int unsigned lv);
		if (rcnt > lv || rcnt >= 12'hFFF)
			return 1'b1;
		rcnt++;
		return 1'b0;
	endfunction

	function automatic bit wait_over(input int unsigned lv);
		if (wcnt > lv || wcnt >= 16'hFFFF)
			return 1'b1;
		wcnt++;
		return 1'b0;
	endfunction

	function automatic logic [7:0] frame_byte(input int unsigned k);
		if (k == 0)
			return 8'h40 | {2'b00, cidx};
		if (k <= 4)
			return 8'(carg >> (8 * (4 - k)));
		return (cidx == 6'd8) ? 8'h87 : 8'h95;
	endfunction

	function automatic void begin_cmd(input logic [5:0] idx, input logic [31:0] arg);
		cidx = idx;
		carg = arg;
		bcnt = '0;
		ph = sdspi_pkg::PH_CMD_SEND;
		xfer(frame_byte(0), 1'b1);
	endfunction

	// Decide what follows the trailing byte of a command.
	function automatic void command_done(input logic [7:0] r);
		if (kind == sdspi_pkg::FUNC_READ || kind == sdspi_pkg::FUNC_WRITE) begin
			if (r != 0) begin
				finish_op(sdspi_pkg::ST_REJECT);
			end else if (kind == sdspi_pkg::FUNC_READ) begin
				ph = sdspi_pkg::PH_RD_TOKEN;
				wcnt = '0;
				xfer(8'hFF, 1'b1);
			end else begin
				ph = sdspi_pkg::PH_WR_TOKEN;
				bcnt = '0;
				xfer(8'hFE, 1'b1);
				res.need_write_data = 1'b1;
			end
			return;
		end
		case (cidx)
			6'd0: begin
				if (r == 8'h01) begin
					ph = sdspi_pkg::PH_GAP;
					bcnt = '0;
					xfer(8'hFF, 1'b0);
				end else if (retry_over(lim.rst)) begin
					finish_op(sdspi_pkg::ST_REJECT);
				end else begin
					begin_cmd(6'd0, 32'h0);
				end
			end
			6'd8: begin
				if (r == 8'h01) begin
					rcnt = '0;
					begin_cmd(6'd55, 32'h0);
				end else if (retry_over(lim.ifc)) begin
					v2 = 1'b0;
					rcnt = '0;
					begin_cmd(6'd55, 32'h0);
				end else begin
					begin_cmd(6'd8, 32'h000001AA);
				end
			end
			6'd55: begin
				begin_cmd(6'd1, 32'h40000000);
			end
			6'd1: begin
				if (rcnt >= lim.opc) begin
					finish_op(sdspi_pkg::ST_TIMEOUT);
				end else begin
					rcnt = rcnt + 12'd1;
					if (r != 0) begin
						begin_cmd(6'd55, 32'h0);
					end else begin
						rcnt = '0;
						sdhc = 1'b0;
						if (v2)
							begin_cmd(6'd58, 32'h0);
						else
							finish_op(sdspi_pkg::ST_OK);
					end
				end
			end
			default: begin
				if (r == 0 || retry_over(8'hFE))
					finish_op(sdspi_pkg::ST_OK);
				else
					begin_cmd(6'd58, 32'h0);
			end
		endcase
	endfunction

	// Advance the local sequencer by one beat and return the result it owes.
	function automatic sdspi_pkg::result_t predict_beat(input sdspi_pkg::item_t it);
		logic [7:0] r;
		r = it.miso_byte;
		res = '0;
		res.mosi_byte = 8'hFF;
		res.op_status = sdspi_pkg::ST_OK;
		if (it.func != sdspi_pkg::FUNC_XCHG) begin
			kind = it.func;
			rcnt = '0;
			wcnt = '0;
			if (it.func == sdspi_pkg::FUNC_INIT) begin
				v2 = 1'b1;
				ph = sdspi_pkg::PH_DUMMY;
				bcnt = '0;
				xfer(8'hFF, 1'b0);
			end else begin
				begin_cmd((it.func == sdspi_pkg::FUNC_READ) ? 6'd17 : 6'd24,
					sdhc ? it.block_number : (it.block_number << 9));
			end
		end else begin
			case (ph)
				sdspi_pkg::PH_DUMMY: begin
					bcnt++;
					if (bcnt < sdspi_pkg::DummyBytes) begin
						xfer(8'hFF, 1'b0);
					end else begin
						rcnt = '0;
						begin_cmd(6'd0, 32'h0);
					end
				end
				sdspi_pkg::PH_CMD_SEND: begin
					bcnt++;
					if (bcnt < 6) begin
						xfer(frame_byte(bcnt), 1'b1);
					end else begin
						ph = sdspi_pkg::PH_CMD_POLL;
						wcnt = '0;
						xfer(8'hFF, 1'b1);
					end
				end
				sdspi_pkg::PH_CMD_POLL: begin
					if (r == 8'hFF && !wait_over(lim.poll)) begin
						xfer(8'hFF, 1'b1);
					end else begin
						lastr = r;
						bcnt = '0;
						ph = (r == 0 && cidx == 6'd58) ? sdspi_pkg::PH_CMD_OCR
							: sdspi_pkg::PH_CMD_TAIL;
						xfer(8'hFF, 1'b1);
					end
				end
				sdspi_pkg::PH_CMD_OCR: begin
					if (bcnt == 0)
						sdhc = r[6];
					bcnt++;
					if (bcnt >= 4)
						ph = sdspi_pkg::PH_CMD_TAIL;
					xfer(8'hFF, 1'b1);
				end
				sdspi_pkg::PH_CMD_TAIL: command_done(lastr);
				sdspi_pkg::PH_GAP: begin
					bcnt++;
					if (bcnt < 2) begin
						xfer(8'hFF, 1'b0);
					end else begin
						rcnt = '0;
						begin_cmd(6'd8, 32'h000001AA);
					end
				end
				sdspi_pkg::PH_RD_TOKEN: begin
					if (r == 8'hFE) begin
						ph = sdspi_pkg::PH_RD_DATA;
						bcnt = '0;
						xfer(8'hFF, 1'b1);
					end else if (wait_over(lim.token)) begin
						finish_op(sdspi_pkg::ST_TIMEOUT);
					end else begin
						xfer(8'hFF, 1'b1);
					end
				end
				sdspi_pkg::PH_RD_DATA: begin
					res.read_byte = r;
					res.read_valid = 1'b1;
					bcnt++;
					if (bcnt >= sdspi_pkg::SectorBytes) begin
						ph = sdspi_pkg::PH_RD_TAIL;
						bcnt = '0;
					end
					xfer(8'hFF, 1'b1);
				end
				sdspi_pkg::PH_RD_TAIL: begin
					bcnt++;
					if (bcnt < 3)
						xfer(8'hFF, 1'b1);
					else
						finish_op(sdspi_pkg::ST_OK);
				end
				sdspi_pkg::PH_WR_TOKEN: begin
					ph = sdspi_pkg::PH_WR_DATA;
					bcnt = '0;
					xfer(it.write_byte, 1'b1);
					res.need_write_data = (sdspi_pkg::SectorBytes > 1);
				end
				sdspi_pkg::PH_WR_DATA: begin
					bcnt++;
					if (bcnt < sdspi_pkg::SectorBytes) begin
						xfer(it.write_byte, 1'b1);
						res.need_write_data = (bcnt + 1 < sdspi_pkg::SectorBytes);
					end else begin
						ph = sdspi_pkg::PH_WR_CRC;
						bcnt = '0;
						xfer(8'hFF, 1'b1);
					end
				end
				sdspi_pkg::PH_WR_CRC: begin
					bcnt++;
					if (bcnt >= 2)
						ph = sdspi_pkg::PH_WR_RESP;
					xfer(8'hFF, 1'b1);
				end
				sdspi_pkg::PH_WR_RESP: begin
					if ((r & 8'h1F) != 8'h05) begin
						finish_op(sdspi_pkg::ST_WR_ERROR);
					end else begin
						ph = sdspi_pkg::PH_WR_BUSY1;
						wcnt = '0;
						xfer(8'hFF, 1'b1);
					end
				end
				sdspi_pkg::PH_WR_BUSY1, sdspi_pkg::PH_WR_BUSY2: begin
					if (r != 0) begin
						if (ph == sdspi_pkg::PH_WR_BUSY1) begin
							ph = sdspi_pkg::PH_WR_GAP;
							xfer(8'hFF, 1'b0);
						end else begin
							finish_op(sdspi_pkg::ST_OK);
						end
					end else if (wait_over(lim.busy)) begin
						finish_op(sdspi_pkg::ST_WR_ERROR);
					end else begin
						xfer(8'hFF, 1'b1);
					end
				end
				sdspi_pkg::PH_WR_GAP: begin
					ph = sdspi_pkg::PH_WR_BUSY2;
					xfer(8'hFF, 1'b1);
				end
				default: ;
			endcase
		end
		res.card_is_sdhc = sdhc;
		return res;
	endfunction

	// A plausible card reply for the current phase, with some noise.
	function automatic logic [7:0] card_reply();
		if ($urandom_range(0, 19) == 0)
			return 8'($urandom);
		case (ph)
			sdspi_pkg::PH_CMD_POLL: begin
				if ($urandom_range(0, 3) == 0)
					return 8'hFF;
				case (cidx)
					6'd0, 6'd55: return 8'h01;
					6'd8: return ($urandom_range(0, 3) == 0) ? 8'h05 : 8'h01;
					6'd1: return 8'($urandom_range(0, 1));
					default: return ($urandom_range(0, 7) == 0) ? 8'h04 : 8'h00;
				endcase
			end
			sdspi_pkg::PH_RD_TOKEN: return ($urandom_range(0, 2) == 0) ? 8'hFE : 8'hFF;
			sdspi_pkg::PH_WR_RESP: return 8'(($urandom & 32'hE0) | 32'h05);
			sdspi_pkg::PH_WR_BUSY1, sdspi_pkg::PH_WR_BUSY2:
				return ($urandom_range(0, 2) != 0) ? 8'h00 : 8'h01;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic add_beat(input sdspi_pkg::func_t f, input logic [31:0] blk,
		input logic [7:0] mb, input logic [7:0] wb);
		sdspi_pkg::item_t it;
		it.func = f;
		it.block_number = blk;
		it.miso_byte = mb;
		it.write_byte = wb;
		pending_beats.push_back(it);
		awaited_results.push_back(predict_beat(it));
	endtask

	task automatic add_exchange();
		add_beat(sdspi_pkg::FUNC_XCHG, 32'($urandom), card_reply(), 8'($urandom));
	endtask

	// Whole operations with card-like replies, some cut short by a new start.
	task automatic run_ops(input int unsigned beats);
		int unsigned n;
		int unsigned pick;
		logic [31:0] blk;
		n = 0;
		while (n < beats) begin
			pick = $urandom_range(0, 99);
			blk = ($urandom_range(0, 9) == 0) ? {32{pick[0]}} : 32'($urandom);
			if (pick < 4)
				add_exchange();
			else if (pick < 34)
				add_beat(sdspi_pkg::FUNC_INIT, blk, 8'($urandom), 8'($urandom));
			else if (pick < 67)
				add_beat(sdspi_pkg::FUNC_READ, blk, 8'($urandom), 8'($urandom));
			else
				add_beat(sdspi_pkg::FUNC_WRITE, blk, 8'($urandom), 8'($urandom));
			n++;
			while (ph != sdspi_pkg::PH_IDLE && n < beats && $urandom_range(0, 399) != 0) begin
				add_exchange();
				n++;
			end
		end
	endtask

	task automatic drain();
		while (pending_beats.size() != 0 || push || awaited_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_limit(input sdspi_pkg::cfg_idx_t idx, input logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			sdspi_pkg::CFG_POLL:  lim.poll = v[7:0];
			sdspi_pkg::CFG_RST:   lim.rst = v[7:0];
			sdspi_pkg::CFG_IFC:   lim.ifc = v[7:0];
			sdspi_pkg::CFG_OPC:   lim.opc = v[11:0];
			sdspi_pkg::CFG_TOKEN: lim.token = v;
			default:              lim.busy = v;
		endcase
	endtask

	task automatic set_all(input logic [15:0] p, input logic [15:0] r, input logic [15:0] i,
		input logic [15:0] o, input logic [15:0] t, input logic [15:0] b);
		set_limit(sdspi_pkg::CFG_POLL, p);
		set_limit(sdspi_pkg::CFG_RST, r);
		set_limit(sdspi_pkg::CFG_IFC, i);
		set_limit(sdspi_pkg::CFG_OPC, o);
		set_limit(sdspi_pkg::CFG_TOKEN, t);
		set_limit(sdspi_pkg::CFG_BUSY, b);
	endtask

	// Input side: offer the oldest pending beat, with random gaps.
	always @(posedge clk)
		in_taken <= arst_n && push && !full;

	always @(negedge clk) begin
		if (in_taken)
			pending_beats.delete(0);
		if (push && !in_taken) begin
			// Hold the offered beat until it is taken.
		end else if (send_gap > 0) begin
			push <= 1'b0;
			send_gap--;
		end else if (pending_beats.size() != 0 && arst_n) begin
			if (!quiet && $urandom_range(0, 9) == 0) begin
				send_gap = $urandom_range(0, 8);
				push <= 1'b0;
			end else begin
				push <= 1'b1;
				func <= pending_beats[0].func;
				block_number <= pending_beats[0].block_number;
				miso_byte <= pending_beats[0].miso_byte;
				write_byte <= pending_beats[0].write_byte;
			end
		end else begin
			push <= 1'b0;
		end
	end

	// Result side: random stalls and one long hold-off.
	always @(negedge clk) begin
		if (hold_request && hold_cnt < HoldCycles) begin
			pop <= 1'b0;
			hold_cnt++;
		end else if (pop_gap > 0) begin
			pop <= 1'b0;
			pop_gap--;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			pop <= 1'b0;
			pop_gap = $urandom_range(0, 8);
		end else begin
			pop <= 1'b1;
		end
	end

	// Check each result beat against the oldest prediction.
	always @(posedge clk) begin
		sdspi_pkg::result_t seen;
		if (arst_n && pop && !empty) begin
			seen.mosi_byte = mosi_byte;
			seen.exchange_request = exchange_request;
			seen.card_select = card_select;
			seen.need_write_data = need_write_data;
			seen.read_byte = read_byte;
			seen.read_valid = read_valid;
			seen.op_done = op_done;
			seen.op_status = sdspi_pkg::status_t'(op_status);
			seen.card_is_sdhc = card_is_sdhc;
			if (awaited_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat %p", seen);
			end else begin
				if (seen !== awaited_results[0]) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %p, got %p",
							awaited_results[0], seen);
				end
				awaited_results.delete(0);
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("sd_card_spi_host_engine_test: errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		func = sdspi_pkg::FUNC_XCHG;
		block_number = '0;
		miso_byte = '0;
		write_byte = '0;
		cfg_we = 1'b0;
		cfg_index = sdspi_pkg::CFG_POLL;
		cfg_data = '0;
		ph = sdspi_pkg::PH_IDLE;
		kind = '0;
		rcnt = '0;
		wcnt = '0;
		bcnt = '0;
		cidx = '0;
		carg = '0;
		sdhc = 1'b0;
		v2 = 1'b1;
		lastr = 8'hFF;
		lim = '{poll: 8'd254, rst: 8'd32, ifc: 8'd254, opc: 12'd4094,
			token: 16'd65534, busy: 16'd65534};
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed: idle report, extreme sector numbers, restarts, init.
		add_beat(sdspi_pkg::FUNC_XCHG, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
		add_beat(sdspi_pkg::FUNC_READ, 32'hFFFF_FFFF, 8'h00, 8'h00);
		add_beat(sdspi_pkg::FUNC_XCHG, 32'h0, 8'h00, 8'hFF);
		add_beat(sdspi_pkg::FUNC_WRITE, 32'h0, 8'hFF, 8'h00);
		repeat (7) add_beat(sdspi_pkg::FUNC_XCHG, 32'h0, 8'h00, 8'hFF);
		add_beat(sdspi_pkg::FUNC_XCHG, 32'h0, 8'hFF, 8'h00);
		add_beat(sdspi_pkg::FUNC_XCHG, 32'h0, 8'hFF, 8'hFF);
		add_beat(sdspi_pkg::FUNC_XCHG, 32'h0, 8'h00, 8'h00);
		add_beat(sdspi_pkg::FUNC_INIT, 32'h0, 8'h00, 8'h00);
		repeat (8) add_exchange();
		drain();

		hold_request = 1'b1;
		run_ops(450);
		drain();

		// Tightest limits: every limit is set to zero.
		set_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		run_ops(300);
		drain();

		set_all(16'd255, 16'd255, 16'd255, 16'd4095, 16'd65535, 16'd65535);
		run_ops(450);
		drain();

		set_all(16'($urandom_range(0, 4)), 16'($urandom_range(0, 3)),
			16'($urandom_range(0, 3)), 16'($urandom_range(1, 6)),
			16'($urandom_range(0, 6)), 16'($urandom_range(0, 4)));
		quiet = 1'b1;
		run_ops(430);
		drain();

		repeat (10) @(negedge clk);
		if (errors == 0)
			$display("sd_card_spi_host_engine_test: clean");
		else
			$display("sd_card_spi_host_engine_test: errors");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/sdspi_pkg.sv
rtl/core/sdspi_fifo.sv
rtl/core/sdspi_front.sv
rtl/core/sdspi_seq.sv
rtl/core/sd_card_spi_host_engine.sv
dv/sd_card_spi_host_engine_test.sv
